FILE: sv/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // reset values of the configuration registers
  localparam logic [THRESH_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [THRESH_W-1:0] ARM_RST      = 16'd1500;
  localparam logic [THRESH_W-1:0] LONG_RST     = 16'd3000;
  localparam logic                PRESSED_RST  = 1'b0;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_ARMED = 2'd2,
    EV_LONG  = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_ARM      = 2'd1,
    REG_LONG     = 2'd2,
    REG_PRESSED  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [THRESH_W-1:0] debounce_time;
    logic [THRESH_W-1:0] arm_time;
    logic [THRESH_W-1:0] long_time;
    logic                active_level;
  } cfg_t;

endpackage

FILE: sv/bpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Configuration register file: thresholds and active pin level.
// ----------------------------------------------------------------------------
module bpc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] wr_idx,
  input  logic [bpc_pkg::THRESH_W-1:0]  wr_data,
  output bpc_pkg::cfg_t                 cfg
);

  bpc_pkg::cfg_t cfg_r;
  bpc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (bpc_pkg::reg_idx_t'(wr_idx))
        bpc_pkg::REG_DEBOUNCE: cfg_nxt.debounce_time = wr_data;
        bpc_pkg::REG_ARM:      cfg_nxt.arm_time      = wr_data;
        bpc_pkg::REG_LONG:     cfg_nxt.long_time     = wr_data;
        bpc_pkg::REG_PRESSED:  cfg_nxt.active_level  = wr_data[0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time <= bpc_pkg::DEBOUNCE_RST;
      cfg_r.arm_time      <= bpc_pkg::ARM_RST;
      cfg_r.long_time     <= bpc_pkg::LONG_RST;
      cfg_r.active_level  <= bpc_pkg::PRESSED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/bpc_classify.sv
// ----------------------------------------------------------------------------
// bpc_classify
// Debounce and press length state, updated once per poll transfer.
// ----------------------------------------------------------------------------
module bpc_classify (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        pin_level,
  input  logic [bpc_pkg::TIME_W-1:0]  now_time,
  input  bpc_pkg::cfg_t               cfg,
  output bpc_pkg::event_t             event_code,
  output logic                        is_held
);

  logic                       last_raw_r, last_raw_nxt;
  logic                       settled_r, settled_nxt;
  logic [bpc_pkg::TIME_W-1:0] change_time_r, change_time_nxt;
  logic [bpc_pkg::TIME_W-1:0] start_time_r, start_time_nxt;
  logic                       armed_given_r, armed_given_nxt;
  logic                       long_given_r, long_given_nxt;

  logic                       raw;
  logic [bpc_pkg::TIME_W-1:0] since_change;
  logic [bpc_pkg::TIME_W-1:0] held_time;
  logic                       bounce_wait;
  logic                       long_hit;
  logic                       arm_hit;

  assign raw          = (pin_level == cfg.active_level);
  assign since_change = now_time - change_time_r;
  assign held_time    = now_time - start_time_r;
  assign bounce_wait  = since_change < {{(bpc_pkg::TIME_W-bpc_pkg::THRESH_W){1'b0}},
                                       cfg.debounce_time};
  assign long_hit     = held_time >= {{(bpc_pkg::TIME_W-bpc_pkg::THRESH_W){1'b0}},
                                     cfg.long_time};
  assign arm_hit      = held_time >= {{(bpc_pkg::TIME_W-bpc_pkg::THRESH_W){1'b0}},
                                     cfg.arm_time};

  always_comb begin
    last_raw_nxt    = last_raw_r;
    settled_nxt     = settled_r;
    change_time_nxt = change_time_r;
    start_time_nxt  = start_time_r;
    armed_given_nxt = armed_given_r;
    long_given_nxt  = long_given_r;
    event_code      = bpc_pkg::EV_NONE;
    if (raw != last_raw_r) begin
      // restart debounce timer
      last_raw_nxt    = raw;
      change_time_nxt = now_time;
    end else if (raw == settled_r || bounce_wait) begin
      if (settled_r) begin
        if (!long_given_r && long_hit) begin
          long_given_nxt = 1'b1;
          event_code     = bpc_pkg::EV_LONG;
        end else if (!armed_given_r && arm_hit) begin
          armed_given_nxt = 1'b1;
          event_code      = bpc_pkg::EV_ARMED;
        end
      end
    end else begin
      settled_nxt = raw;
      if (raw) begin
        start_time_nxt  = now_time;
        armed_given_nxt = 1'b0;
        long_given_nxt  = 1'b0;
      end else if (!long_given_r) begin
        event_code = bpc_pkg::EV_SHORT;
      end
    end
  end

  assign is_held = settled_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b0;
      settled_r     <= 1'b0;
      change_time_r <= '0;
      start_time_r  <= '0;
      armed_given_r <= 1'b0;
      long_given_r  <= 1'b0;
    end else if (step) begin
      last_raw_r    <= last_raw_nxt;
      settled_r     <= settled_nxt;
      change_time_r <= change_time_nxt;
      start_time_r  <= start_time_nxt;
      armed_given_r <= armed_given_nxt;
      long_given_r  <= long_given_nxt;
    end
  end

  a_hold_event_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    step && (event_code == bpc_pkg::EV_LONG || event_code == bpc_pkg::EV_ARMED)
    |-> settled_r)
    else $error("hold event without settled press");

  a_short_releases: assert property (@(posedge clk) disable iff (!rst_n)
    step && event_code == bpc_pkg::EV_SHORT |=> !settled_r)
    else $error("short event did not release");

  a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
    step && event_code == bpc_pkg::EV_LONG |-> !long_given_r)
    else $error("long event given twice in one press");

endmodule

FILE: sv/button_press_classifier_core.sv
// ----------------------------------------------------------------------------
// button_press_classifier_core
// Debounced push button with short / armed / long press classification.
//
//   channel  ports                dir  payload
//   in       in_tvalid/tready     in   tdata[0] pin_level, [32:1] now_time
//   out      out_tvalid/tready    out  tdata[1:0] event_code, [2] is_held
//   cfg      cfg_valid/ready      in   cfg_index, cfg_data (always ready)
//
// One poll per cycle sustained while out_tready stays high; each poll is
// registered in the input register and then in the result register.
// Debounce state advances when a poll moves from the input register into the
// result register, so each poll sees the state left by the one before.
// A stalled output holds the result and the next poll waits in the input
// register; in_tready drops only when both registers are full.
// Synchronous active-low reset: released state and reset thresholds.
// ----------------------------------------------------------------------------
module button_press_classifier_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [0] pin_level, [32:1] now_time, [39:33] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [1:0] event_code, [2] is_held, [7:3] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::THRESH_W-1:0]  cfg_data
);

  bpc_pkg::cfg_t cfg;

  logic                       in_valid_r, in_valid_nxt;
  logic                       pin_r;
  logic [bpc_pkg::TIME_W-1:0] time_r;
  logic                       out_valid_r, out_valid_nxt;
  bpc_pkg::event_t            ev_r;
  logic                       held_r;

  logic                       advance;
  logic                       in_xfer;
  bpc_pkg::event_t            ev_c;
  logic                       held_c;

  assign cfg_ready = 1'b1;

  bpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  bpc_classify u_cls (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .pin_level  (pin_r),
    .now_time   (time_r),
    .cfg        (cfg),
    .event_code (ev_c),
    .is_held    (held_c)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pin_r  <= in_tdata[0];
      time_r <= in_tdata[bpc_pkg::TIME_W:1];
    end
    if (advance) begin
      ev_r   <= ev_c;
      held_r <= held_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, held_r, ev_r};

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("result lost after advance");

  a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(time_r) && $stable(pin_r))
    else $error("pending poll dropped");

  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_tready)
    else $error("not ready with empty input register");

endmodule

FILE: tb/button_press_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// button_press_classifier_core_tb
// Self-checking bench for the debounced button classifier. A short scripted
// sequence checks reset behavior, exact debounce and hold thresholds and
// timestamp wrap. Seven register settings follow, zero and all-ones among
// them, each with randomized press/bounce/release sequences and some noise.
// Every poll is predicted in the bench and compared with the DUT result.
// Both stream sides idle at random, and the result side holds off long
// enough to back up the input twice.
// ----------------------------------------------------------------------------
module button_press_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASES      = 7;
  localparam int PHASE_POLLS = 250;

  typedef struct packed {
    bpc_pkg::event_t ev;
    logic            held;
  } poll_result_t;

  typedef struct packed {
    logic            pin;
    logic [31:0]     stamp;
    logic            typed;
    bpc_pkg::event_t ev;
    logic            held;
  } poll_row_t;

  typedef struct packed {
    logic        last_raw;
    logic        settled;
    logic        armed_sent;
    logic        long_sent;
    logic [31:0] change_ms;
    logic [31:0] press_ms;
  } button_state_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [39:0]                  in_tdata = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [7:0]                   out_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  bpc_pkg::reg_idx_t            cfg_index = bpc_pkg::REG_DEBOUNCE;
  logic [bpc_pkg::THRESH_W-1:0] cfg_data = '0;

  button_state_t pred;
  bpc_pkg::cfg_t pred_cfg;
  poll_result_t  pending_results[$];
  logic [31:0]   now_ms;
  int            n_fail = 0;
  int            polls_sent = 0;
  int            burst_left = 0;
  int            press_burst = 0;
  int            hold_asks = 0;
  int            idle_cycles = 0;

  // scripted polls under the reset settings (active level 0)
  poll_row_t script [22] = '{
    '{1'b1, 32'd0,          1'b1, bpc_pkg::EV_NONE,  1'b0},
    '{1'b0, 32'd10,         1'b1, bpc_pkg::EV_NONE,  1'b0},
    '{1'b0, 32'd39,         1'b1, bpc_pkg::EV_NONE,  1'b0},
    '{1'b0, 32'd40,         1'b1, bpc_pkg::EV_NONE,  1'b1},
    '{1'b0, 32'd1539,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b0, 32'd1540,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b0, 32'd1541,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b1, 32'd1600,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b1, 32'd1629,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b1, 32'd1630,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b0, 32'd2000,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b0, 32'd2030,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b0, 32'd5030,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b0, 32'd5031,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b1, 32'd5100,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b1, 32'd5200,       1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b0, 32'hFFFF_FFF0,  1'b1, bpc_pkg::EV_NONE,  1'b0},
    '{1'b0, 32'h0000_000E,  1'b1, bpc_pkg::EV_NONE,  1'b1},
    '{1'b0, 32'hFFFF_FFFF,  1'b1, bpc_pkg::EV_LONG,  1'b1},
    '{1'b0, 32'hFFFF_FFFF,  1'b1, bpc_pkg::EV_ARMED, 1'b1},
    '{1'b1, 32'd0,          1'b0, bpc_pkg::EV_NONE,  1'b0},
    '{1'b1, 32'd100,        1'b0, bpc_pkg::EV_NONE,  1'b0}
  };

  button_press_classifier_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [0] pin_level, [32:1] now_time, [39:33] zero
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [1:0] event_code, [2] is_held, [7:3] zero
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the button state by one poll and return the event it gives.
  function automatic bpc_pkg::event_t classify_poll(logic pin, logic [31:0] stamp);
    logic        raw;
    logic [31:0] since_change;
    logic [31:0] held_ms;
    raw          = (pin == pred_cfg.active_level);
    since_change = stamp - pred.change_ms;
    held_ms      = stamp - pred.press_ms;
    if (raw != pred.last_raw) begin
      pred.last_raw  = raw;
      pred.change_ms = stamp;
      return bpc_pkg::EV_NONE;
    end
    if (raw == pred.settled || since_change < {16'd0, pred_cfg.debounce_time}) begin
      if (pred.settled) begin
        if (!pred.long_sent && held_ms >= {16'd0, pred_cfg.long_time}) begin
          pred.long_sent = 1'b1;
          return bpc_pkg::EV_LONG;
        end
        if (!pred.armed_sent && held_ms >= {16'd0, pred_cfg.arm_time}) begin
          pred.armed_sent = 1'b1;
          return bpc_pkg::EV_ARMED;
        end
      end
      return bpc_pkg::EV_NONE;
    end
    pred.settled = raw;
    if (raw) begin
      pred.press_ms   = stamp;
      pred.armed_sent = 1'b0;
      pred.long_sent  = 1'b0;
      return bpc_pkg::EV_NONE;
    end
    return pred.long_sent ? bpc_pkg::EV_NONE : bpc_pkg::EV_SHORT;
  endfunction

  task automatic send_poll(input logic pin, input logic [31:0] stamp, input logic typed,
                           input bpc_pkg::event_t typed_ev, input logic typed_held);
    poll_result_t res;
    int           gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, stamp, pin};
    do @(posedge clk); while (!in_tready);
    res.ev   = classify_poll(pin, stamp);
    res.held = pred.settled;
    if (typed) begin
      res.ev   = typed_ev;
      res.held = typed_held;
    end
    pending_results.push_back(res);
    polls_sent++;
    if (press_burst > 0) begin
      press_burst--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Hold one pin level for n polls spread over roughly span_ms.
  task automatic send_level(input logic pin, input int unsigned span_ms, input int n);
    int unsigned step_max;
    step_max = 2 * (span_ms / n) + 1;
    repeat (n) begin
      now_ms = now_ms + $urandom_range(0, step_max);
      send_poll(pin, now_ms, 1'b0, bpc_pkg::EV_NONE, 1'b0);
    end
  endtask

  // Bounce in, hold for a random length around the thresholds, bounce out.
  task automatic play_press();
    logic        on;
    int unsigned db;
    int unsigned span;
    on   = pred_cfg.active_level;
    db   = 32'(pred_cfg.debounce_time);
    span = (pred_cfg.arm_time > pred_cfg.long_time) ? 32'(pred_cfg.arm_time)
                                                    : 32'(pred_cfg.long_time);
    repeat ($urandom_range(0, 3)) begin
      send_level(on, $urandom_range(0, db), 1);
      send_level(!on, $urandom_range(0, db), 1);
    end
    send_level(on, db + $urandom_range(0, span + span / 3 + 4), $urandom_range(2, 10));
    repeat ($urandom_range(0, 3)) begin
      send_level(!on, $urandom_range(0, db), 1);
      send_level(on, $urandom_range(0, db), 1);
    end
    send_level(!on, db + $urandom_range(0, db + 8), $urandom_range(2, 5));
  endtask

  task automatic play_noise();
    int unsigned kind;
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 7);
      if (kind == 0)
        now_ms = now_ms + $urandom;
      else if (kind == 1)
        now_ms = now_ms - $urandom_range(0, 50);
      else
        now_ms = now_ms + $urandom_range(0, 3 * pred_cfg.debounce_time + 3);
      send_poll(1'($urandom_range(0, 1)), now_ms, 1'b0, bpc_pkg::EV_NONE, 1'b0);
    end
  endtask

  // Write all four registers in one burst of transfers.
  task automatic load_config(input bpc_pkg::cfg_t c);
    bpc_pkg::reg_idx_t            idx;
    logic [bpc_pkg::THRESH_W-1:0] val;
    idx = bpc_pkg::REG_DEBOUNCE;
    cfg_valid <= 1'b1;
    repeat (4) begin
      case (idx)
        bpc_pkg::REG_DEBOUNCE: val = c.debounce_time;
        bpc_pkg::REG_ARM:      val = c.arm_time;
        bpc_pkg::REG_LONG:     val = c.long_time;
        default: begin
          // upper bits are don't-care for the level register
          val    = (bpc_pkg::THRESH_W)'($urandom);
          val[0] = c.active_level;
        end
      endcase
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        bpc_pkg::REG_DEBOUNCE: pred_cfg.debounce_time = val;
        bpc_pkg::REG_ARM:      pred_cfg.arm_time      = val;
        bpc_pkg::REG_LONG:     pred_cfg.long_time     = val;
        default:               pred_cfg.active_level  = val[0];
      endcase
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // result side: random stall patterns, plus a long hold-off when asked
  always @(posedge clk) begin : ready_gen
    int mode;
    int mode_left;
    int hold_left;
    int holds_seen;
    if (holds_seen != hold_asks) begin
      holds_seen = hold_asks;
      hold_left  = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= ((mode_left % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    poll_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: event_code %0d, is_held %0d", out_tdata[1:0], out_tdata[2]);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.ev) begin
          $error("event_code: expected %0d, got %0d", want.ev, out_tdata[1:0]);
          n_fail++;
        end
        if (out_tdata[2] !== want.held) begin
          $error("is_held: expected %0d, got %0d", want.held, out_tdata[2]);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("** button_press_classifier_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bpc_pkg::cfg_t phase_table [5];
    bpc_pkg::cfg_t next_cfg;
    int            polls_target;
    phase_table[0] = '{16'd30,    16'd1500,  16'd3000,  1'b1};
    phase_table[1] = '{16'd0,     16'd0,     16'd0,     1'b0};
    phase_table[2] = '{16'd65535, 16'd65535, 16'd65535, 1'b1};
    phase_table[3] = '{16'd8,     16'd600,   16'd250,   1'b0};
    phase_table[4] = '{16'd3,     16'd40,    16'd90,    1'b1};
    pred     = '0;
    pred_cfg = '{bpc_pkg::DEBOUNCE_RST, bpc_pkg::ARM_RST, bpc_pkg::LONG_RST,
                 bpc_pkg::PRESSED_RST};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      send_poll(script[i].pin, script[i].stamp, script[i].typed, script[i].ev, script[i].held);
    drain();

    now_ms = $urandom;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 5) begin
        next_cfg = phase_table[ph];
      end else begin
        next_cfg.debounce_time = (bpc_pkg::THRESH_W)'($urandom_range(0, 40));
        next_cfg.arm_time      = (bpc_pkg::THRESH_W)'($urandom_range(0, 2000));
        next_cfg.long_time     = (bpc_pkg::THRESH_W)'($urandom_range(0, 2000));
        next_cfg.active_level  = 1'($urandom_range(0, 1));
      end
      load_config(next_cfg);
      // back up the input: result side holds off while polls keep coming
      if (ph == 0 || ph == 4) begin
        hold_asks++;
        press_burst = 40;
      end
      polls_target = polls_sent + PHASE_POLLS;
      while (polls_sent < polls_target) begin
        if ($urandom_range(0, 9) == 0)
          play_noise();
        else
          play_press();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (n_fail == 0)
      $display("** button_press_classifier_core: PASSED **");
    else
      $display("** button_press_classifier_core: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
sv/bpc_pkg.sv
sv/bpc_cfg_regs.sv
sv/bpc_classify.sv
sv/button_press_classifier_core.sv
tb/button_press_classifier_core_tb.sv
